### design/tdt_pkg.sv
// Package for the three-phase firing delay timer.
// Holds the item structs, configuration codes and reset values; no dependencies.
`timescale 1ns / 1ps

package tdt_pkg;

  localparam int PHASES     = 3;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 16;
  localparam int IDX_BITS   = 2;

  // Configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_PULSE_TICKS   = 2'd0;
  localparam logic [IDX_BITS-1:0] REG_NO_FIRE_LIMIT = 2'd1;
  localparam logic [IDX_BITS-1:0] REG_FULL_ON_LIMIT = 2'd2;

  // Register reset values
  localparam logic [CFG_BITS-1:0] PULSE_TICKS_RST   = 16'd500;
  localparam logic [CFG_BITS-1:0] NO_FIRE_LIMIT_RST = 16'd8000;
  localparam logic [CFG_BITS-1:0] FULL_ON_LIMIT_RST = 16'd10;

  typedef struct packed {
    logic                zero_cross_a;
    logic                zero_cross_b;
    logic                zero_cross_c;
    logic [CFG_BITS-1:0] delay_ticks;
  } in_item_t;

  typedef struct packed {
    logic gate_a;
    logic gate_b;
    logic gate_c;
  } out_item_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] pulse_ticks;
    logic [CFG_BITS-1:0] no_fire_limit;
    logic [CFG_BITS-1:0] full_on_limit;
  } cfg_t;

endpackage

### design/tdt_phase.sv
// One phase of the firing delay timer: zero-cross handling, delay and pulse timing.
// Depends on tdt_pkg for widths and the configuration struct.
`timescale 1ns / 1ps

module tdt_phase (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         zc,
  input  logic [tdt_pkg::CFG_BITS-1:0] delay,
  input  tdt_pkg::cfg_t                cfg,
  output logic                         gate,
  output logic                         gate_next
);

  logic [tdt_pkg::COUNT_BITS-1:0] tick_count, tick_count_next;
  logic [tdt_pkg::COUNT_BITS-1:0] count_target, count_target_next;
  logic                           running, running_next;
  logic                           pending, pending_next;
  logic                           expire;

  assign expire = (tick_count >= count_target);

  // Next state for one tick
  always_comb begin
    tick_count_next   = tick_count;
    count_target_next = count_target;
    running_next      = running;
    pending_next      = pending;
    gate_next         = gate;
    if (zc) begin
      gate_next = 1'b0;
      if (delay < cfg.no_fire_limit) begin
        running_next = 1'b0;
        if (delay > cfg.full_on_limit) begin
          tick_count_next   = '0;
          count_target_next = delay;
          pending_next      = 1'b1;
          running_next      = 1'b1;
        end else begin
          gate_next = 1'b1;
        end
      end
    end else if (running) begin
      if (expire) begin
        tick_count_next = '0;
        if (pending) begin
          gate_next         = 1'b1;
          count_target_next = cfg.pulse_ticks;
          pending_next      = 1'b0;
        end else begin
          running_next = 1'b0;
          gate_next    = 1'b0;
        end
      end else begin
        tick_count_next = tick_count + 1'b1;
      end
    end
  end

  // Phase state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count   <= '0;
      count_target <= '0;
      running      <= 1'b0;
      pending      <= 1'b0;
      gate         <= 1'b0;
    end else if (en) begin
      tick_count   <= tick_count_next;
      count_target <= count_target_next;
      running      <= running_next;
      pending      <= pending_next;
      gate         <= gate_next;
    end
  end

endmodule

### design/three_phase_firing_delay_timer.sv
// The input register holds an accepted item, the result register its result item.
// Throughput: one item per cycle while the output is ready; the input register
// refills as the result register is taken and holds one item while the output stalls.
// Reset: synchronous, active high; gates off, timers stopped, registers at
// pulse_ticks 500, no_fire_limit 8000, full_on_limit 10.
`timescale 1ns / 1ps

module three_phase_firing_delay_timer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  tdt_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tdt_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [tdt_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [tdt_pkg::CFG_BITS-1:0] cfg_data
);

  tdt_pkg::in_item_t                in_reg;
  logic                             in_vld;
  tdt_pkg::cfg_t                    cfg;
  logic                             advance;
  logic [tdt_pkg::PHASES-1:0]       zc;
  logic [tdt_pkg::PHASES-1:0]       gate;
  logic [tdt_pkg::PHASES-1:0]       gate_next;

  assign cfg_ready = 1'b1;
  assign advance   = in_vld && (!out_valid || out_ready);
  assign in_ready  = !in_vld || advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks   <= tdt_pkg::PULSE_TICKS_RST;
      cfg.no_fire_limit <= tdt_pkg::NO_FIRE_LIMIT_RST;
      cfg.full_on_limit <= tdt_pkg::FULL_ON_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tdt_pkg::REG_PULSE_TICKS:   cfg.pulse_ticks   <= cfg_data;
        tdt_pkg::REG_NO_FIRE_LIMIT: cfg.no_fire_limit <= cfg_data;
        tdt_pkg::REG_FULL_ON_LIMIT: cfg.full_on_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
  end

  assign zc = {in_reg.zero_cross_c, in_reg.zero_cross_b, in_reg.zero_cross_a};

  // Phase timers, one per phase
  for (genvar p = 0; p < tdt_pkg::PHASES; p++) begin : g_phase
    tdt_phase u_phase (
      .clk       (clk),
      .rst       (rst),
      .en        (advance),
      .zc        (zc[p]),
      .delay     (in_reg.delay_ticks),
      .cfg       (cfg),
      .gate      (gate[p]),
      .gate_next (gate_next[p])
    );
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data.gate_a <= gate_next[0];
      out_data.gate_b <= gate_next[1];
      out_data.gate_c <= gate_next[2];
    end
  end

  // Checks
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input not ready with empty result register");

  a_advance_fills: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("result register not loaded after advance");

  a_out_matches_state: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.gate_a == gate[0] && out_data.gate_b == gate[1] &&
                   out_data.gate_c == gate[2]))
    else $error("result item differs from phase gate state");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (in_vld && out_valid && !out_ready) |=> in_vld)
    else $error("pending item lost during output stall");

endmodule

### sim/firing_checker.sv
// Checker for the three-phase firing delay timer: mirrors the registers and
// per-phase timers, predicts the gate item for each tick and compares outputs.
// Depends on tdt_pkg for the item structs, register indexes and reset values.
`timescale 1ns / 1ps

module firing_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  tdt_pkg::in_item_t            in_data,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  tdt_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [tdt_pkg::IDX_BITS-1:0] cfg_index,
  input  logic [tdt_pkg::CFG_BITS-1:0] cfg_data,
  output int                           errors,
  output int                           pending
);

  // Shadow registers
  logic [tdt_pkg::CFG_BITS-1:0]   pulse_len;
  logic [tdt_pkg::CFG_BITS-1:0]   no_fire;
  logic [tdt_pkg::CFG_BITS-1:0]   full_on;

  // Per-phase timer state
  logic [tdt_pkg::COUNT_BITS-1:0] ticks     [tdt_pkg::PHASES];
  logic [tdt_pkg::COUNT_BITS-1:0] target    [tdt_pkg::PHASES];
  logic                           running   [tdt_pkg::PHASES];
  logic                           fire_next [tdt_pkg::PHASES];
  logic                           gate_on   [tdt_pkg::PHASES];

  tdt_pkg::out_item_t             expected_gates [$];

  // One timer tick for all phases; returns the gate levels after it
  task automatic advance_timers(input tdt_pkg::in_item_t tick,
                                output tdt_pkg::out_item_t gates);
    logic zc [tdt_pkg::PHASES];
    zc[0] = tick.zero_cross_a;
    zc[1] = tick.zero_cross_b;
    zc[2] = tick.zero_cross_c;
    for (int p = 0; p < tdt_pkg::PHASES; p++) begin
      if (zc[p]) begin
        // zero-cross: gate drops unless fired full on; counter is not stepped this tick
        gate_on[p] = 1'b0;
        if (tick.delay_ticks < no_fire) begin
          running[p] = 1'b0;
          if (tick.delay_ticks > full_on) begin
            ticks[p]     = '0;
            target[p]    = tick.delay_ticks;
            fire_next[p] = 1'b1;
            running[p]   = 1'b1;
          end else begin
            gate_on[p] = 1'b1;
          end
        end
      end else if (running[p]) begin
        // overrun counts as expiry too
        if (ticks[p] >= target[p]) begin
          ticks[p] = '0;
          if (fire_next[p]) begin
            gate_on[p]   = 1'b1;
            target[p]    = pulse_len;
            fire_next[p] = 1'b0;
          end else begin
            running[p] = 1'b0;
            gate_on[p] = 1'b0;
          end
        end else begin
          ticks[p] = ticks[p] + 1'b1;
        end
      end
    end
    gates.gate_a = gate_on[0];
    gates.gate_b = gate_on[1];
    gates.gate_c = gate_on[2];
  endtask

  task automatic check_gate(input string name, input logic want, input logic got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tdt_pkg::out_item_t want;
    if (rst) begin
      pulse_len = tdt_pkg::PULSE_TICKS_RST;
      no_fire   = tdt_pkg::NO_FIRE_LIMIT_RST;
      full_on   = tdt_pkg::FULL_ON_LIMIT_RST;
      for (int p = 0; p < tdt_pkg::PHASES; p++) begin
        ticks[p]     = '0;
        target[p]    = '0;
        running[p]   = 1'b0;
        fire_next[p] = 1'b0;
        gate_on[p]   = 1'b0;
      end
      expected_gates.delete();
      errors = 0;
      pending <= 0;
    end else begin
      // the user is to write registers only while the block is idle; the block does not enforce it
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tdt_pkg::REG_PULSE_TICKS:   pulse_len = cfg_data;
          tdt_pkg::REG_NO_FIRE_LIMIT: no_fire   = cfg_data;
          tdt_pkg::REG_FULL_ON_LIMIT: full_on   = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        advance_timers(in_data, want);
        expected_gates.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (expected_gates.size() == 0) begin
          errors++;
          $display("%0t: unexpected gate item, expected none actual %b", $time, out_data);
        end else begin
          want = expected_gates.pop_front();
          check_gate("gate_a", want.gate_a, out_data.gate_a);
          check_gate("gate_b", want.gate_b, out_data.gate_b);
          check_gate("gate_c", want.gate_c, out_data.gate_c);
        end
      end
      pending <= expected_gates.size();
    end
  end

endmodule

### sim/testbench.sv
// Top of the firing delay timer testbench: clock, reset, tick and register
// stimulus, verdict. Depends on tdt_pkg, the timer RTL and firing_checker.
`timescale 1ns / 1ps

module testbench;

  // unmapped register index, writes to it must be ignored
  localparam logic [tdt_pkg::IDX_BITS-1:0] REG_SPARE = 2'd3;
  localparam int TAIL_CYCLES = 10;

  logic                         clk       = 1'b0;
  logic                         rst       = 1'b1;
  logic                         in_valid  = 1'b0;
  logic                         in_ready;
  tdt_pkg::in_item_t            in_data   = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  tdt_pkg::out_item_t           out_data;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [tdt_pkg::IDX_BITS-1:0] cfg_index = '0;
  logic [tdt_pkg::CFG_BITS-1:0] cfg_data  = '0;
  int                           errors;
  int                           pending;

  bit                           steady = 1'b0;
  int                           zc_wait [tdt_pkg::PHASES];
  logic [tdt_pkg::CFG_BITS-1:0] cur_no_fire;
  logic [tdt_pkg::CFG_BITS-1:0] cur_full_on;

  three_phase_firing_delay_timer u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  firing_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Output back-pressure, off during the steady stretch
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 17);
  end

  function automatic tdt_pkg::in_item_t make_tick(bit a, bit b, bit c,
                                                  logic [tdt_pkg::CFG_BITS-1:0] d);
    tdt_pkg::in_item_t t;
    t.zero_cross_a = a;
    t.zero_cross_b = b;
    t.zero_cross_c = c;
    t.delay_ticks  = d;
    return t;
  endfunction

  // Zero-crosses per phase at random spacing, with the odd stray one
  function automatic bit zc_due(int p);
    bit hit;
    hit = (zc_wait[p] == 0) || ($urandom_range(0, 24) == 0);
    if (hit) zc_wait[p] = $urandom_range(8, 100);
    else zc_wait[p]--;
    return hit;
  endfunction

  // Small delays so timers expire; some full-width and some at the limits
  function automatic logic [tdt_pkg::CFG_BITS-1:0] pick_delay();
    case ($urandom_range(0, 9))
      0, 1: return tdt_pkg::CFG_BITS'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return cur_no_fire;
          1: return cur_no_fire - 1'b1;
          2: return cur_full_on;
          default: return cur_full_on + 1'b1;
        endcase
      end
      default: return tdt_pkg::CFG_BITS'($urandom_range(0, 64));
    endcase
  endfunction

  task automatic send_tick(input tdt_pkg::in_item_t t);
    while (!steady && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic run_ticks(input int n);
    repeat (n) send_tick(make_tick(zc_due(0), zc_due(1), zc_due(2), pick_delay()));
  endtask

  // Stop sending and wait until every gate item has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tdt_pkg::IDX_BITS-1:0] idx,
                           input logic [tdt_pkg::CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_settings(input logic [tdt_pkg::CFG_BITS-1:0] pulse,
                               input logic [tdt_pkg::CFG_BITS-1:0] no_fire,
                               input logic [tdt_pkg::CFG_BITS-1:0] full_on,
                               input bit spare);
    write_reg(tdt_pkg::REG_PULSE_TICKS, pulse);
    write_reg(tdt_pkg::REG_NO_FIRE_LIMIT, no_fire);
    write_reg(tdt_pkg::REG_FULL_ON_LIMIT, full_on);
    if (spare) write_reg(REG_SPARE, tdt_pkg::CFG_BITS'($urandom));
    cfg_valid   <= 1'b0;
    cur_no_fire = no_fire;
    cur_full_on = full_on;
  endtask

  initial begin
    for (int p = 0; p < tdt_pkg::PHASES; p++) zc_wait[p] = $urandom_range(0, 40);
    cur_no_fire = tdt_pkg::NO_FIRE_LIMIT_RST;
    cur_full_on = tdt_pkg::FULL_ON_LIMIT_RST;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks at reset settings
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd0));
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 16'd0));      // full on at once
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 16'd10));     // at full-on limit
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 16'd11));     // A armed, just above
    send_tick(make_tick(1'b0, 1'b1, 1'b0, 16'd7999));   // B armed, just under no-fire
    send_tick(make_tick(1'b0, 1'b0, 1'b1, 16'd8000));   // C left unfired
    send_tick(make_tick(1'b1, 1'b1, 1'b1, 16'hFFFF));   // gates drop, timers carry on
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'hAAAA));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'h5555));
    repeat (10) send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'hFFFF)); // A fires
    send_tick(make_tick(1'b1, 1'b0, 1'b0, 16'd12));     // re-arm A mid-pulse
    send_tick(make_tick(1'b0, 1'b1, 1'b1, 16'd1));
    send_tick(make_tick(1'b0, 1'b0, 1'b0, 16'd0));
    drain();

    // Random ticks across register settings
    load_settings(16'd3, 16'd40, 16'd5, 1'b0);
    run_ticks(180);
    drain();
    load_settings(16'd0, 16'd30, 16'd0, 1'b0);          // one-tick pulse
    run_ticks(160);
    drain();
    steady = 1'b1;
    load_settings(16'd12, 16'd50, 16'd8, 1'b0);
    run_ticks(200);
    drain();
    steady = 1'b0;
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);  // limits conflict, all high
    run_ticks(100);
    drain();
    load_settings(16'd5, 16'd0, 16'd0, 1'b1);           // nothing ever fires
    run_ticks(100);
    drain();
    load_settings(16'd1, 16'hFFFF, 16'd0, 1'b0);        // any nonzero delay below 0xFFFF arms
    run_ticks(150);
    drain();
    load_settings(16'd7, 16'd20, 16'd25, 1'b0);         // full-on above no-fire
    run_ticks(120);
    drain();
    repeat (2) begin
      load_settings(tdt_pkg::CFG_BITS'($urandom_range(0, 15)),
                    tdt_pkg::CFG_BITS'($urandom_range(10, 60)),
                    tdt_pkg::CFG_BITS'($urandom_range(0, 12)), 1'b1);
      run_ticks(120);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Run limit, far beyond the slowest passing run
  initial begin
    #2_400_000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
design/tdt_pkg.sv
design/tdt_phase.sv
design/three_phase_firing_delay_timer.sv
sim/firing_checker.sv
sim/testbench.sv
